>>> rtl/hlg_pkg.sv
// Shared types and constants for the Huber loss gradient unit.
`timescale 1ns / 1ps
package hlg_pkg;
  localparam int unsigned DeltaW  = 31;
  localparam int unsigned CountW  = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned GradW   = 33;
  localparam int unsigned MeanW   = 48;
  localparam int unsigned SumW    = 64;
  localparam int unsigned MulSplit = 17;

  localparam logic [CfgIdxW-1:0] CfgDelta = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCount = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_GDIV, S_MDIV, S_OUT
  } back_state_e;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;
endpackage

>>> rtl/hlg_fifo.sv
// Two-entry request queue used between the stages and at the result side.
`timescale 1ns / 1ps
module hlg_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

>>> rtl/hlg_front.sv
// Front stage: forms the difference and classifies it against delta.
`timescale 1ns / 1ps
module hlg_front import hlg_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] prediction_i,
  input  logic [DATA_WIDTH-1:0] target_i,
  input  logic                  last_element_i,
  input  logic [DeltaW-1:0]     delta_i,
  output logic [DATA_WIDTH+3:0] entry_o
);
  localparam int unsigned MW = DATA_WIDTH + 1;
  logic signed [MW-1:0] diff;
  logic [MW-1:0]        mag;
  logic                 neg, in_delta;

  always_comb begin
    diff     = MW'($signed(prediction_i)) - MW'($signed(target_i));
    neg      = diff[MW-1];
    mag      = neg ? MW'(-diff) : MW'(diff);
    // Both sides widened to 64 bits so the compare holds for data widths up to 63 bits.
    in_delta = 64'(mag) <= 64'(delta_i);
    entry_o  = {last_element_i, neg, in_delta, mag};
  end
endmodule

>>> rtl/hlg_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hlg_div import hlg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [SumW-1:0]   quo_q;
  logic [CountW-1:0] rem_q, div_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [CountW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rsp_o  = '{done: done_q, quotient: quo_q};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? CountW'(rem_sh - {1'b0, div_q}) : rem_sh[CountW-1:0];
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/hlg_back.sv
// Back stage: Huber term, saturating sum, gradient and mean divisions.
`timescale 1ns / 1ps
module hlg_back import hlg_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH+3:0] entry_i,
  input  logic                  in_empty_i,
  output logic                  in_pop_o,
  input  logic [DeltaW-1:0]     delta_i,
  input  logic [CountW-1:0]     count_i,
  output div_req_t              div_req_o,
  input  div_rsp_t              div_rsp_i,
  output logic [GradW+MeanW:0]  result_o,
  output logic                  out_push_o,
  input  logic                  out_full_i
);
  localparam int unsigned MW = DATA_WIDTH + 1;
  localparam int unsigned BW = MW + 1;
  localparam int unsigned HW = DeltaW + BW - MulSplit;
  localparam int unsigned PW = DeltaW + BW;

  back_state_e state_q, state_d;
  logic [MW-1:0]                  mag_q;
  logic                           neg_q, inside_q, last_q;
  logic [DeltaW+MulSplit-1:0]     plo_q;
  logic [HW-1:0]                  phi_q;
  logic [SumW-1:0]                sum_q;
  logic [GradW-1:0]               grad_q;
  logic [MeanW-1:0]               mean_q;
  logic [DeltaW-1:0]              mul_a;
  logic [BW-1:0]                  mul_b;
  logic [PW-1:0]                  prod;
  logic [127:0]                   prod_sh;
  logic [SumW-1:0]                term;
  logic [SumW:0]                  sum_add;
  logic [CountW-1:0]              n;

  assign n = (count_i == '0) ? CountW'(1) : count_i;

  always_comb begin
    mul_a = inside_q ? DeltaW'(mag_q) : delta_i;
    mul_b = inside_q ? BW'(mag_q) : BW'({mag_q, 1'b0}) - BW'(delta_i);
    prod    = PW'(plo_q) + (PW'(phi_q) << MulSplit);
    prod_sh = 128'(prod) >> (FRAC_BITS + 1);
    term    = (|prod_sh[127:SumW]) ? '1 : prod_sh[SumW-1:0];
    sum_add = {1'b0, sum_q} + {1'b0, term};
  end

  always_comb begin
    state_d    = state_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    div_req_o  = '{start: 1'b0, dividend: '0, divisor: n};
    unique case (state_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = SumW'(inside_q ? DeltaW'(mag_q) : delta_i);
        state_d = S_GDIV;
      end
      S_GDIV: begin
        if (div_rsp_i.done) begin
          if (last_q) begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = sum_q;
            state_d = S_MDIV;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_MDIV: if (div_rsp_i.done) state_d = S_OUT;
      S_OUT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign result_o = {grad_q, last_q ? mean_q : MeanW'(0), last_q};

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      {last_q, neg_q, inside_q, mag_q} <= entry_i;
    end
    if (state_q == S_MUL) begin
      plo_q <= (DeltaW+MulSplit)'(mul_a * mul_b[MulSplit-1:0]);
      phi_q <= HW'(mul_a * mul_b[BW-1:MulSplit]);
    end
    if (state_q == S_GDIV && div_rsp_i.done) begin
      grad_q <= neg_q ? GradW'(-div_rsp_i.quotient[GradW-1:0])
                      : div_rsp_i.quotient[GradW-1:0];
    end
    if (state_q == S_MDIV && div_rsp_i.done) begin
      mean_q <= (|div_rsp_i.quotient[SumW-1:MeanW]) ? '1
                                                     : div_rsp_i.quotient[MeanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ACC) begin
        sum_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
      end else if (state_q == S_MDIV && div_rsp_i.done) begin
        sum_q <= '0;
      end
    end
  end
endmodule

>>> rtl/huber_loss_gradient_unit.sv
// Top level of the Huber loss gradient unit.
//
// Input queue: an item (prediction, target, last_element) is taken when push is
// high and full is low. Result queue: the oldest result sits on the result
// ports while empty is low and leaves when pop is high. The configuration
// channel is always ready; write it only while the block is idle.
// Each item is classified on entry and queued (two entries) for the back
// stage, which takes the entry, does a split multiplication, accumulates,
// runs the shared one-bit-per-cycle divider and takes its quotient for the
// gradient and, on a last item, runs it again for the mean loss, then
// queues the result. The shared divider sets the rate. A stalled receiver
// leaves results in the two-entry result queue; once that fills, the back
// stage waits and the input queue fills behind it. Reset empties both
// queues, clears the loss sum and sets delta to 65536 (1.0 with 16 fraction
// bits) and the element count to 1.
`timescale 1ns / 1ps
module huber_loss_gradient_unit import hlg_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [DATA_WIDTH-1:0] prediction_i,
  input  logic [DATA_WIDTH-1:0] target_i,
  input  logic                  last_element_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [GradW-1:0]      gradient_o,
  output logic [MeanW-1:0]      mean_loss_o,
  output logic                  loss_valid_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgW-1:0]       cfg_data_i
);
  localparam int unsigned EW = DATA_WIDTH + 4;
  localparam int unsigned RW = GradW + MeanW + 1;

  logic [DeltaW-1:0] delta_q;
  logic [CountW-1:0] count_q;
  logic [EW-1:0]     entry_w, entry_r;
  logic              q_empty, q_pop;
  logic [RW-1:0]     res_w, res_r;
  logic              res_push, res_full;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DeltaW'(65536);
      count_q <= CountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgDelta) delta_q <= cfg_data_i[DeltaW-1:0];
      if (cfg_index_i == CfgCount) count_q <= cfg_data_i[CountW-1:0];
    end
  end

  hlg_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .prediction_i, .target_i, .last_element_i,
    .delta_i(delta_q), .entry_o(entry_w)
  );

  hlg_fifo #(.WIDTH(EW)) u_mid_q (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(entry_w), .full_o(full),
    .pop_i(q_pop), .rdata_o(entry_r), .empty_o(q_empty)
  );

  hlg_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  hlg_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .entry_i(entry_r), .in_empty_i(q_empty), .in_pop_o(q_pop),
    .delta_i(delta_q), .count_i(count_q), .div_req_o(div_req), .div_rsp_i(div_rsp),
    .result_o(res_w), .out_push_o(res_push), .out_full_i(res_full)
  );

  hlg_fifo #(.WIDTH(RW)) u_res_q (
    .clk_i, .rst_ni, .push_i(res_push), .wdata_i(res_w), .full_o(res_full),
    .pop_i(pop), .rdata_o(res_r), .empty_o(empty)
  );

  assign {gradient_o, mean_loss_o, loss_valid_o} = res_r;
endmodule

>>> rtl/hlg_checker.sv
// Port-level checker for the Huber loss gradient unit, with its bind.
`timescale 1ns / 1ps
module hlg_checker import hlg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [GradW-1:0]   gradient_o,
  input logic [MeanW-1:0]   mean_loss_o,
  input logic               loss_valid_o,
  input logic               cfg_ready_o
);
  // A result that is not the last of a set carries no loss.
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !loss_valid_o) |-> (mean_loss_o == '0))
    else $error("mean loss set on a result without loss_valid");

  // The gradient magnitude never exceeds delta, which is below 2^31.
  a_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (gradient_o[GradW-1] == gradient_o[GradW-2]))
    else $error("gradient outside the delta range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration channel not ready");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(gradient_o)))
    else $error("waiting result changed before it was taken");
endmodule

bind huber_loss_gradient_unit hlg_checker u_hlg_checker (
  .clk_i, .rst_ni, .empty, .pop, .gradient_o, .mean_loss_o, .loss_valid_o,
  .cfg_ready_o
);

>>> sim/huber_loss_gradient_unit_tb.sv
// Self-checking testbench for the Huber loss gradient unit.
`timescale 1ns / 1ps
module huber_loss_gradient_unit_tb;
  import hlg_pkg::*;

  typedef struct packed {
    logic [GradW-1:0] gradient;
    logic [MeanW-1:0] mean_loss;
    logic             loss_valid;
  } huber_result_t;

  class huber_scoreboard;
    logic [DeltaW-1:0] delta;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   loss_sum;
    huber_result_t     pending[$];
    int unsigned       errors;

    function void clear_state();
      delta    = 31'd65536;
      count    = 17'd1;
      loss_sum = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CfgDelta) begin
        delta = data[DeltaW-1:0];
      end else if (idx == CfgCount) begin
        count = data[CountW-1:0];
      end
    endfunction

    function void note_request(logic signed [31:0] pred, logic signed [31:0] targ,
                               logic last);
      logic [63:0]  n, mag, gmag, term, quot;
      logic [127:0] prod;
      logic signed [63:0] d;
      huber_result_t r;
      n    = (count == 0) ? 64'd1 : 64'(count);
      d    = 64'(pred) - 64'(targ);
      mag  = d[63] ? -d : d;
      if (mag <= 64'(delta)) begin
        gmag = mag / n;
        term = (mag * mag) >> 17;
      end else begin
        gmag = 64'(delta) / n;
        prod = 128'(delta) * 128'(2 * mag - 64'(delta));
        prod = prod >> 17;
        term = (prod[127:64] != 0) ? '1 : prod[63:0];
      end
      loss_sum = (loss_sum > ~term) ? '1 : loss_sum + term;
      r.gradient   = d[63] ? GradW'(-gmag) : GradW'(gmag);
      r.mean_loss  = '0;
      r.loss_valid = last;
      if (last) begin
        quot        = loss_sum / n;
        r.mean_loss = (quot > 64'hFFFF_FFFF_FFFF) ? '1 : quot[MeanW-1:0];
        loss_sum    = '0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(huber_result_t got);
      huber_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result gradient %h", got.gradient);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.gradient !== exp_r.gradient) begin
        $error("gradient: expected %h actual %h", exp_r.gradient, got.gradient);
        errors++;
      end
      if (got.mean_loss !== exp_r.mean_loss) begin
        $error("mean_loss: expected %h actual %h", exp_r.mean_loss, got.mean_loss);
        errors++;
      end
      if (got.loss_valid !== exp_r.loss_valid) begin
        $error("loss_valid: expected %b actual %b", exp_r.loss_valid, got.loss_valid);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 20000;
  // An index that names no register; writes to it are ignored.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  logic [31:0] prediction_i = '0, target_i = '0;
  logic last_element_i = 1'b0;
  logic [GradW-1:0] gradient_o;
  logic [MeanW-1:0] mean_loss_o;
  logic loss_valid_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  huber_scoreboard board = new();
  int unsigned idle_cycles = 0;
  logic stall_mode = 1'b0;

  always #1 clk_i = ~clk_i;

  huber_loss_gradient_unit DUT (.*);

  // Receiver: pops on a pattern of its own, checks what it takes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        board.check_result('{gradient_o, mean_loss_o, loss_valid_o});
      end
      pop <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      if (($urandom_range(0, 199)) == 0) stall_mode <= ~stall_mode;
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(logic [31:0] p, logic [31:0] t, logic last);
    push           <= 1'b1;
    prediction_i   <= p;
    target_i       <= t;
    last_element_i <= last;
    do @(posedge clk_i); while (full);
    board.note_request(p, t, last);
  endtask

  task automatic pause_sender();
    push <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // The write ends with an idle cycle so that back-to-back writes never drive
  // valid twice in one step.
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value(logic [31:0] scale);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * scale)) - $signed(scale));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom() & 32'h0003_FFFF;
    endcase
  endfunction

  task automatic random_phase(int unsigned items, logic [31:0] scale);
    int unsigned burst;
    burst = $urandom_range(1, 12);
    for (int unsigned i = 0; i < items; i++) begin
      send_item(rand_value(scale), rand_value(scale), $urandom_range(0, 5) == 0 || i == items - 1);
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
    end
    drain();
  endtask

  initial begin
    board.clear_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, inside and outside delta, zero diff, edge settings of delta and count.
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_8000, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 32'h0000_8000, 1'b0);
    send_item(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_item(32'h1234_5678, 32'h1234_5678, 1'b1);
    send_item(32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();
    write_cfg(CfgCount, 32'd0);
    write_cfg(CfgDelta, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();
    write_cfg(CfgDelta, 32'd0);
    write_cfg(CfgCount, 32'h0001_FFFF);
    send_item(32'h0000_0003, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h0000_0000, 1'b1);
    drain();
    write_cfg(CfgUnused, 32'hFFFF_FFFF);
    write_cfg(CfgCount, 32'd65536);
    write_cfg(CfgDelta, 32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    drain();

    // Random phases across several settings.
    write_cfg(CfgDelta, 32'h0001_0000);
    write_cfg(CfgCount, 32'd1);
    random_phase(300, 32'h0002_0000);
    write_cfg(CfgDelta, 32'h7FFF_FFFF);
    write_cfg(CfgCount, 32'd65536);
    random_phase(300, 32'h4000_0000);
    write_cfg(CfgDelta, $urandom() & 32'h000F_FFFF);
    write_cfg(CfgCount, $urandom_range(1, 100));
    random_phase(300, 32'h0010_0000);
    write_cfg(CfgDelta, $urandom());
    write_cfg(CfgCount, $urandom_range(0, 131071));
    random_phase(250, 32'h0100_0000);
    write_cfg(CfgDelta, 32'd0);
    write_cfg(CfgCount, 32'd3);
    random_phase(250, 32'h0001_0000);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/hlg_pkg.sv
rtl/hlg_fifo.sv
rtl/hlg_front.sv
rtl/hlg_div.sv
rtl/hlg_back.sv
rtl/huber_loss_gradient_unit.sv
rtl/hlg_checker.sv
sim/huber_loss_gradient_unit_tb.sv
